// ----- src/fbrq_pkg.sv -----
package fbrq_pkg;

  localparam int MaxBuffers = 8;
  localparam int IdxW       = $clog2(MaxBuffers);
  localparam int CntW       = $clog2(MaxBuffers + 1);
  localparam int CfgW       = 4;
  localparam int ModeW      = 2;
  localparam int StatusW    = 3;

  typedef struct packed {
    logic rebuild;
    logic exec;
  } cmd_t;

endpackage

// ----- src/frame_buffer_recycle_queues.sv -----
// Frame buffer recycling queues: tracks up to eight display buffers by index in a
// free FIFO and an in-flight FIFO. tuser carries the operation (commit, acquire,
// retire) and tdata the buffer index to commit. Each item is executed in the cycle
// it is accepted and yields one result item through an output register, so the
// block takes one item per clock; s_axis_tready_o drops only while that register
// holds a result the downstream side has not taken. A write to the buffer count
// reinitializes both queues, leaving buffers 2 to count-1 free in ascending order.
module frame_buffer_recycle_queues (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,     // buffer_count
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [2:0] buffer_index, [7:3] zero
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [2:0] result_index, [6:3] free_count,
                                       // [10:7] inflight_count, [15:11] zero
  output logic [2:0]  m_axis_tuser_o   // [2:0] status
);
  import fbrq_pkg::*;

  cmd_t              cmd;
  logic [IdxW-1:0]   result_index;
  logic [CntW-1:0]   free_count;
  logic [CntW-1:0]   inflight_count;

  fbrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  fbrq_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_wdata_i      (cfg_wdata_i),
    .mode_i           (s_axis_tuser_i),
    .buffer_index_i   (s_axis_tdata_i[IdxW-1:0]),
    .result_index_o   (result_index),
    .status_o         (m_axis_tuser_o),
    .free_count_o     (free_count),
    .inflight_count_o (inflight_count)
  );

  assign m_axis_tdata_o = {5'b0, inflight_count, free_count, result_index};

endmodule

// ----- src/fbrq_ctrl.sv -----
module fbrq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fbrq_pkg::cmd_t cmd_o
);
  import fbrq_pkg::*;

  typedef enum logic {
    OutEmpty,
    OutFull
  } state_e;

  state_e state_q, state_d;
  logic   exec;

  assign in_ready_o  = (state_q == OutEmpty) || out_ready_i;
  assign exec        = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == OutFull);

  assign cmd_o.exec    = exec;
  assign cmd_o.rebuild = cfg_we_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      OutEmpty: begin
        if (exec) state_d = OutFull;
      end
      OutFull: begin
        if (!exec && out_ready_i) state_d = OutEmpty;
      end
      default: state_d = OutEmpty;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= OutEmpty;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/fbrq_datapath.sv -----
module fbrq_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fbrq_pkg::cmd_t                cmd_i,
  input  logic [fbrq_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic [fbrq_pkg::ModeW-1:0]    mode_i,
  input  logic [fbrq_pkg::IdxW-1:0]     buffer_index_i,
  output logic [fbrq_pkg::IdxW-1:0]     result_index_o,
  output logic [fbrq_pkg::StatusW-1:0]  status_o,
  output logic [fbrq_pkg::CntW-1:0]     free_count_o,
  output logic [fbrq_pkg::CntW-1:0]     inflight_count_o
);
  import fbrq_pkg::*;

  typedef enum logic [ModeW-1:0] {
    ModeCommit  = 2'd0,
    ModeAcquire = 2'd1,
    ModeRetire  = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    StDone       = 3'd0,
    StQueued     = 3'd1,
    StRange      = 3'd2,
    StNoneFree   = 3'd3,
    StNoneFlight = 3'd4
  } status_e;

  logic [CntW-1:0]       count_q;
  logic [IdxW-1:0]       free_ring_q [MaxBuffers];
  logic [MaxBuffers-1:0] free_wr_q;
  logic [IdxW-1:0]       free_head_q, free_head_d;
  logic [CntW-1:0]       free_len_q, free_len_d;
  logic [IdxW-1:0]       flight_ring_q [MaxBuffers];
  logic [IdxW-1:0]       flight_head_q, flight_head_d;
  logic [CntW-1:0]       flight_len_q, flight_len_d;
  logic [MaxBuffers-1:0] mask_q, mask_d;

  logic [IdxW-1:0]       res_q, res_d;
  status_e               status_q, status_d;
  logic [CntW-1:0]       free_cnt_q, flight_cnt_q;

  logic [IdxW-1:0]       free_head_val;
  logic [IdxW-1:0]       free_tail;
  logic [IdxW-1:0]       flight_tail;
  logic                  free_we, flight_we;
  logic [IdxW-1:0]       free_wdata;

  logic [CntW-1:0]       count_new;
  logic [MaxBuffers-1:0] mask_new;

  // Clamp the written count and build the initial membership.
  always_comb begin
    if (cfg_wdata_i < CfgW'(2)) begin
      count_new = CntW'(2);
    end else if (cfg_wdata_i > CfgW'(MaxBuffers)) begin
      count_new = CntW'(MaxBuffers);
    end else begin
      count_new = CntW'(cfg_wdata_i);
    end
    for (int i = 0; i < MaxBuffers; i++) begin
      mask_new[i] = (CntW'(i) >= CntW'(2)) && (CntW'(i) < count_new);
    end
  end

  // A free slot not written since the last rebuild holds its initial index.
  assign free_head_val = free_wr_q[free_head_q] ? free_ring_q[free_head_q]
                                                : free_head_q + IdxW'(2);
  assign free_tail     = IdxW'(CntW'(free_head_q) + free_len_q);
  assign flight_tail   = IdxW'(CntW'(flight_head_q) + flight_len_q);

  always_comb begin
    free_head_d   = free_head_q;
    free_len_d    = free_len_q;
    flight_head_d = flight_head_q;
    flight_len_d  = flight_len_q;
    mask_d        = mask_q;
    free_we       = 1'b0;
    flight_we     = 1'b0;
    free_wdata    = flight_ring_q[flight_head_q];
    res_d         = '0;
    status_d      = StDone;
    unique case (mode_e'(mode_i))
      ModeCommit: begin
        if (CntW'(buffer_index_i) >= count_q) begin
          status_d = StRange;
        end else if (mask_q[buffer_index_i]) begin
          status_d = StQueued;
        end else if (flight_len_q < CntW'(MaxBuffers)) begin
          flight_we              = 1'b1;
          flight_len_d           = flight_len_q + CntW'(1);
          mask_d[buffer_index_i] = 1'b1;
        end
      end
      ModeAcquire: begin
        if (free_len_q == '0) begin
          status_d = StNoneFree;
        end else begin
          res_d                 = free_head_val;
          free_head_d           = free_head_q + IdxW'(1);
          free_len_d            = free_len_q - CntW'(1);
          mask_d[free_head_val] = 1'b0;
        end
      end
      ModeRetire: begin
        if (flight_len_q == '0) begin
          status_d = StNoneFlight;
        end else begin
          res_d         = flight_ring_q[flight_head_q];
          flight_head_d = flight_head_q + IdxW'(1);
          flight_len_d  = flight_len_q - CntW'(1);
          if (free_len_q < CntW'(MaxBuffers)) begin
            free_we    = 1'b1;
            free_len_d = free_len_q + CntW'(1);
          end
        end
      end
      default: begin
        status_d = StDone;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= CntW'(2);
      free_wr_q     <= '0;
      free_head_q   <= '0;
      free_len_q    <= '0;
      flight_head_q <= '0;
      flight_len_q  <= '0;
      mask_q        <= '0;
    end else if (cmd_i.rebuild) begin
      count_q       <= count_new;
      free_wr_q     <= '0;
      free_head_q   <= '0;
      free_len_q    <= count_new - CntW'(2);
      flight_head_q <= '0;
      flight_len_q  <= '0;
      mask_q        <= mask_new;
    end else if (cmd_i.exec) begin
      free_head_q   <= free_head_d;
      free_len_q    <= free_len_d;
      flight_head_q <= flight_head_d;
      flight_len_q  <= flight_len_d;
      mask_q        <= mask_d;
      if (free_we) free_wr_q[free_tail] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && !cmd_i.rebuild) begin
      if (free_we) free_ring_q[free_tail] <= free_wdata;
      if (flight_we) flight_ring_q[flight_tail] <= buffer_index_i;
      res_q        <= res_d;
      status_q     <= status_d;
      free_cnt_q   <= free_len_d;
      flight_cnt_q <= flight_len_d;
    end
  end

  assign result_index_o   = res_q;
  assign status_o         = status_q;
  assign free_count_o     = free_cnt_q;
  assign inflight_count_o = flight_cnt_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(mask_q) == int'(free_len_q) + int'(flight_len_q))
    else $error("membership mask disagrees with queue lengths");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_q >> count_q) == '0)
    else $error("buffer beyond count marked as queued");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rebuild |=> (flight_len_q == '0) && (free_len_q == count_q - CntW'(2)))
    else $error("queues not reinitialized after count write");

endmodule

// ----- tb/frame_buffer_recycle_queues_test.sv -----
module frame_buffer_recycle_queues_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fbrq_pkg::*;

  localparam int StallLimit = 2000;

  typedef enum logic [ModeW-1:0] {
    OP_COMMIT  = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_RETIRE  = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE        = 3'd0,
    ST_QUEUED      = 3'd1,
    ST_RANGE       = 3'd2,
    ST_NONE_FREE   = 3'd3,
    ST_NONE_FLIGHT = 3'd4
  } status_e;

  typedef struct packed {
    logic [IdxW-1:0] index;
    status_e         status;
    logic [CntW-1:0] free_cnt;
    logic [CntW-1:0] flight_cnt;
  } outcome_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CfgW-1:0]   cfg_wdata = '0;
  logic              s_valid = 1'b0;
  logic              s_ready;
  logic [7:0]        s_tdata = '0;
  logic [ModeW-1:0]  s_tuser = '0;
  logic              m_valid;
  logic              m_ready = 1'b0;
  logic [15:0]       m_tdata;
  logic [StatusW-1:0] m_tuser;

  // Predicted queue state.
  int                nbuf;
  logic [IdxW-1:0]   free_ring[MaxBuffers];
  logic [IdxW-1:0]   flight_ring[MaxBuffers];
  int                free_head, free_len, flight_head, flight_len;
  logic [MaxBuffers-1:0] in_queue;

  outcome_t          expected_results[$];
  int                mismatches = 0;
  int                quiet_cycles = 0;
  logic              idling = 1'b1;

  frame_buffer_recycle_queues u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic void rebuild_queues();
    int i;
    free_head   = 0;
    free_len    = 0;
    flight_head = 0;
    flight_len  = 0;
    in_queue    = '0;
    for (i = 2; i < nbuf; i++) begin
      free_ring[free_len] = IdxW'(i);
      free_len++;
      in_queue[i] = 1'b1;
    end
  endfunction

  function automatic outcome_t apply_op(op_e op, logic [IdxW-1:0] idx);
    outcome_t r;
    logic [IdxW-1:0] b;
    r.index  = '0;
    r.status = ST_DONE;
    case (op)
      OP_COMMIT: begin
        if (int'(idx) >= nbuf) begin
          r.status = ST_RANGE;
        end else if (in_queue[idx]) begin
          r.status = ST_QUEUED;
        end else if (flight_len < MaxBuffers) begin
          flight_ring[(flight_head + flight_len) % MaxBuffers] = idx;
          flight_len++;
          in_queue[idx] = 1'b1;
        end
      end
      OP_ACQUIRE: begin
        if (free_len == 0) begin
          r.status = ST_NONE_FREE;
        end else begin
          b = free_ring[free_head];
          free_head = (free_head + 1) % MaxBuffers;
          free_len--;
          in_queue[b] = 1'b0;
          r.index = b;
        end
      end
      OP_RETIRE: begin
        if (flight_len == 0) begin
          r.status = ST_NONE_FLIGHT;
        end else begin
          b = flight_ring[flight_head];
          flight_head = (flight_head + 1) % MaxBuffers;
          flight_len--;
          if (free_len < MaxBuffers) begin
            free_ring[(free_head + free_len) % MaxBuffers] = b;
            free_len++;
          end
          r.index = b;
        end
      end
      default: ;
    endcase
    r.free_cnt   = CntW'(free_len);
    r.flight_cnt = CntW'(flight_len);
    return r;
  endfunction

  task automatic send_op(op_e op, logic [IdxW-1:0] idx);
    if (idling) begin
      while ($urandom_range(99) < 6) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_tdata <= {5'b0, idx};
    s_tuser <= op;
    do @(posedge clk_i); while (!s_ready);
    expected_results.push_back(apply_op(op, idx));
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_buffer_count(logic [CfgW-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    nbuf = (value < 2) ? 2 : (value > MaxBuffers) ? MaxBuffers : int'(value);
    rebuild_queues();
  endtask

  task automatic test_reset_state();
    send_op(OP_ACQUIRE, 3'd0);
    send_op(OP_RETIRE, 3'd0);
    send_op(OP_COMMIT, 3'd2);
    send_op(OP_COMMIT, 3'd7);
    send_op(OP_COMMIT, 3'd1);
    send_op(OP_COMMIT, 3'd1);
    send_op(OP_UNUSED, 3'd5);
    send_op(OP_RETIRE, 3'd0);
    send_op(OP_ACQUIRE, 3'd0);
    send_op(OP_ACQUIRE, 3'd0);
  endtask

  task automatic test_full_count();
    set_buffer_count(4'd15);
    send_op(OP_ACQUIRE, 3'd0);
    send_op(OP_ACQUIRE, 3'd0);
    send_op(OP_COMMIT, 3'd0);
    send_op(OP_COMMIT, 3'd2);
    send_op(OP_COMMIT, 3'd4);
    send_op(OP_RETIRE, 3'd0);
    send_op(OP_RETIRE, 3'd0);
    repeat (7) send_op(OP_ACQUIRE, 3'd0);
  endtask

  task automatic test_count_clamp();
    set_buffer_count(4'd0);
    send_op(OP_COMMIT, 3'd2);
    set_buffer_count(4'd1);
    send_op(OP_COMMIT, 3'd1);
    set_buffer_count(4'd9);
    send_op(OP_COMMIT, 3'd7);
    set_buffer_count(4'd5);
    send_op(OP_COMMIT, 3'd4);
    send_op(OP_COMMIT, 3'd5);
  endtask

  task automatic test_random_traffic(int n_items);
    int ph, k, r, n_cand, per_phase;
    int cand[MaxBuffers];
    logic [CfgW-1:0] cnt;
    per_phase = n_items / 12;
    for (ph = 0; ph < 12; ph++) begin
      cnt = (ph == 0) ? 4'd8 : (ph == 1) ? 4'd2 : CfgW'($urandom_range(15));
      set_buffer_count(cnt);
      idling = (ph != 3);
      for (k = 0; k < per_phase; k++) begin
        if (ph == 5 && k == per_phase / 2) wait_drained();
        r = $urandom_range(99);
        if (r < 40) begin
          n_cand = 0;
          for (int i = 0; i < nbuf; i++) begin
            if (!in_queue[i]) begin
              cand[n_cand] = i;
              n_cand++;
            end
          end
          if (n_cand == 0) send_op(OP_COMMIT, IdxW'($urandom_range(7)));
          else send_op(OP_COMMIT, IdxW'(cand[$urandom_range(n_cand - 1)]));
        end else if (r < 65) begin
          send_op(OP_ACQUIRE, IdxW'($urandom_range(7)));
        end else if (r < 88) begin
          send_op(OP_RETIRE, IdxW'($urandom_range(7)));
        end else begin
          send_op(op_e'($urandom_range(3)), IdxW'($urandom_range(7)));
        end
      end
    end
    idling = 1'b1;
  endtask

  always @(posedge clk_i) begin
    m_ready <= !idling || ($urandom_range(99) >= 6);
  end

  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (m_valid && m_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item: tdata %h tuser %0d", m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[2:0] !== want.index) begin
          $error("result_index: expected %0d, got %0d", want.index, m_tdata[2:0]);
          mismatches++;
        end
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          mismatches++;
        end
        if (m_tdata[6:3] !== want.free_cnt) begin
          $error("free_count: expected %0d, got %0d", want.free_cnt, m_tdata[6:3]);
          mismatches++;
        end
        if (m_tdata[10:7] !== want.flight_cnt) begin
          $error("inflight_count: expected %0d, got %0d", want.flight_cnt, m_tdata[10:7]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("[frame_buffer_recycle_queues] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    nbuf = 2;
    rebuild_queues();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_full_count();
    test_count_clamp();
    test_random_traffic(1700);
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[frame_buffer_recycle_queues] OK");
    end else begin
      $display("[frame_buffer_recycle_queues] ERROR");
    end
    $finish;
  end

endmodule
